// ----- hw/rtl/affine2x2_decompose_top_assert.svh -----
// assertion helpers included by the top-level rtl file
`ifndef AFFINE2X2_DECOMPOSE_TOP_ASSERT_SVH
`define AFFINE2X2_DECOMPOSE_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define A2D_ASSERT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication, checked out of reset
`define A2D_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ----- hw/rtl/a2d_pkg.sv -----
`timescale 1ns / 1ps
package a2d_pkg;

    // field widths of the stream beats
    localparam int IN_W     = 16;
    localparam int ANG_W    = 16;
    localparam int SCALE_W  = 18;
    localparam int SHEAR_W  = 24;
    localparam int TURN_W   = 32;

    // cordic datapath
    localparam int CORDIC_XW       = 28;
    localparam int CORDIC_PRESCALE = 8;
    localparam logic [TURN_W-1:0] TURN_QUARTER = 32'h4000_0000;
    localparam logic [TURN_W-1:0] TURN_ROUND   = 32'h0000_8000;

    // saturation bounds
    localparam logic signed [SHEAR_W-1:0] SHEAR_MAX = {1'b0, {(SHEAR_W-1){1'b1}}};
    localparam logic signed [SHEAR_W-1:0] SHEAR_MIN = {1'b1, {(SHEAR_W-1){1'b0}}};
    localparam logic signed [SCALE_W-1:0] SCALE_MAX = {1'b0, {(SCALE_W-1){1'b1}}};
    localparam logic signed [SCALE_W-1:0] SCALE_MIN = {1'b1, {(SCALE_W-1){1'b0}}};

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ZERO_NORM = 2'd1,
        ST_SHEAR_SAT = 2'd2
    } t_status;

    // atan(2^-i) with 2^32 units per turn
    function automatic logic [TURN_W-1:0] atan_turn(input logic [4:0] idx);
        logic [TURN_W-1:0] v;
        case (idx)
            5'd0:    v = 32'h2000_0000;
            5'd1:    v = 32'h12E4_051E;
            5'd2:    v = 32'h09FB_385B;
            5'd3:    v = 32'h0511_11D4;
            5'd4:    v = 32'h028B_0D43;
            5'd5:    v = 32'h0145_D7E1;
            5'd6:    v = 32'h00A2_F61E;
            5'd7:    v = 32'h0051_7C55;
            5'd8:    v = 32'h0028_BE53;
            5'd9:    v = 32'h0014_5F2F;
            5'd10:   v = 32'h000A_2F98;
            5'd11:   v = 32'h0005_17CC;
            5'd12:   v = 32'h0002_8BE6;
            5'd13:   v = 32'h0001_45F3;
            5'd14:   v = 32'h0000_A2FA;
            5'd15:   v = 32'h0000_517D;
            5'd16:   v = 32'h0000_28BE;
            5'd17:   v = 32'h0000_145F;
            5'd18:   v = 32'h0000_0A30;
            5'd19:   v = 32'h0000_0518;
            5'd20:   v = 32'h0000_028C;
            5'd21:   v = 32'h0000_0146;
            5'd22:   v = 32'h0000_00A3;
            5'd23:   v = 32'h0000_0051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/a2d_cordic.sv -----
`timescale 1ns / 1ps
module a2d_cordic import a2d_pkg::*; #(
    parameter int STAGES = 16,
    parameter int DIN_W  = 17,
    parameter int SIDE_W = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [DIN_W-1:0] i_x,
    input  logic signed [DIN_W-1:0] i_y,
    input  logic [SIDE_W-1:0]       i_side,
    output logic                    o_valid,
    output logic [TURN_W-1:0]       o_z,
    output logic [SIDE_W-1:0]       o_side
);

    localparam int XW = CORDIC_XW;

    logic signed [XW-1:0] r_x [0:STAGES];
    logic signed [XW-1:0] r_y [0:STAGES];
    logic [TURN_W-1:0]    r_z [0:STAGES];
    logic [SIDE_W-1:0]    r_side [0:STAGES];
    logic [STAGES:0]      r_v;

    logic signed [XW-1:0] n_x [0:STAGES];
    logic signed [XW-1:0] n_y [0:STAGES];
    logic [TURN_W-1:0]    n_z [0:STAGES];

    // quarter-turn fold into the right half plane, then one rotation per stage
    always_comb begin
        logic signed [XW-1:0] xe;
        logic signed [XW-1:0] ye;
        xe = XW'(i_x) <<< CORDIC_PRESCALE;
        ye = XW'(i_y) <<< CORDIC_PRESCALE;
        if (xe < 0) begin
            if (ye >= 0) begin
                n_x[0] = ye;
                n_y[0] = -xe;
                n_z[0] = TURN_QUARTER;
            end else begin
                n_x[0] = -ye;
                n_y[0] = xe;
                n_z[0] = -TURN_QUARTER;
            end
        end else begin
            n_x[0] = xe;
            n_y[0] = ye;
            n_z[0] = '0;
        end
        for (int k = 1; k <= STAGES; k++) begin
            if (!r_y[k-1][XW-1]) begin
                n_x[k] = r_x[k-1] + (r_y[k-1] >>> (k-1));
                n_y[k] = r_y[k-1] - (r_x[k-1] >>> (k-1));
                n_z[k] = r_z[k-1] + atan_turn(5'(k-1));
            end else begin
                n_x[k] = r_x[k-1] - (r_y[k-1] >>> (k-1));
                n_y[k] = r_y[k-1] + (r_x[k-1] >>> (k-1));
                n_z[k] = r_z[k-1] - atan_turn(5'(k-1));
            end
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[STAGES-1:0], i_valid};
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int k = 0; k <= STAGES; k++) begin
                r_x[k] <= n_x[k];
                r_y[k] <= n_y[k];
                r_z[k] <= n_z[k];
            end
            for (int k = 1; k <= STAGES; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid = r_v[STAGES];
    assign o_z     = r_z[STAGES];
    assign o_side  = r_side[STAGES];

endmodule

// ----- hw/rtl/a2d_sqrt.sv -----
`timescale 1ns / 1ps
module a2d_sqrt #(
    parameter int RW     = 17,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [2*RW-1:0]   i_rad,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [RW-1:0]     o_root,
    output logic [SIDE_W-1:0] o_side
);

    localparam int RADW = 2 * RW;
    localparam int RMW  = RW + 3;

    logic [RADW-1:0]   r_rad  [0:RW-1];
    logic [RMW-1:0]    r_rem  [0:RW-1];
    logic [RW-1:0]     r_root [0:RW-1];
    logic [SIDE_W-1:0] r_side [0:RW];
    logic [RW:0]       r_v;
    logic [RW-1:0]     r_n;

    logic [RADW-1:0]   n_rad  [0:RW-1];
    logic [RMW-1:0]    n_rem  [0:RW-1];
    logic [RW-1:0]     n_root [0:RW-1];
    logic [RW-1:0]     n_n;

    // one root bit per stage, two radicand bits brought down each time
    always_comb begin
        logic [RADW-1:0] c_rad;
        logic [RMW-1:0]  c_rem;
        logic [RMW-1:0]  c_cur;
        logic [RMW-1:0]  c_trial;
        logic [RW-1:0]   c_root;
        for (int k = 0; k < RW; k++) begin
            if (k == 0) begin
                c_rad  = i_rad;
                c_rem  = '0;
                c_root = '0;
            end else begin
                c_rad  = r_rad[k-1];
                c_rem  = r_rem[k-1];
                c_root = r_root[k-1];
            end
            c_cur   = {c_rem[RMW-3:0], c_rad[RADW-1:RADW-2]};
            c_trial = {{(RMW-RW-2){1'b0}}, c_root, 2'b01};
            if (c_cur >= c_trial) begin
                n_rem[k]  = c_cur - c_trial;
                n_root[k] = {c_root[RW-2:0], 1'b1};
            end else begin
                n_rem[k]  = c_cur;
                n_root[k] = {c_root[RW-2:0], 1'b0};
            end
            n_rad[k] = {c_rad[RADW-3:0], 2'b00};
        end
        // round to nearest: step up when the remainder exceeds the root
        n_n = r_root[RW-1] + RW'(r_rem[RW-1] > RMW'(r_root[RW-1]));
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[RW-1:0], i_valid};
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int k = 0; k < RW; k++) begin
                r_rad[k]  <= n_rad[k];
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
            end
            for (int k = 1; k <= RW; k++) begin
                r_side[k] <= r_side[k-1];
            end
            r_n <= n_n;
        end
    end

    assign o_valid = r_v[RW];
    assign o_root  = r_n;
    assign o_side  = r_side[RW];

endmodule

// ----- hw/rtl/a2d_div.sv -----
`timescale 1ns / 1ps
module a2d_div #(
    parameter int NW     = 34,
    parameter int DW     = 17,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NW-1:0]     i_num,
    input  logic [DW-1:0]     i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [NW-1:0]     o_quot,
    output logic [SIDE_W-1:0] o_side
);

    logic [NW-1:0]     r_num  [0:NW-1];
    logic [DW-1:0]     r_rem  [0:NW-1];
    logic [DW-1:0]     r_den  [0:NW-1];
    logic [SIDE_W-1:0] r_side [0:NW-1];
    logic [NW-1:0]     r_v;

    logic [NW-1:0]     n_num [0:NW-1];
    logic [DW-1:0]     n_rem [0:NW-1];
    logic [DW-1:0]     n_den [0:NW-1];

    // restoring division, one quotient bit per stage shifted in behind the dividend
    always_comb begin
        logic [NW-1:0] c_num;
        logic [DW-1:0] c_rem;
        logic [DW-1:0] c_den;
        logic [DW:0]   c_cur;
        logic          c_ge;
        for (int k = 0; k < NW; k++) begin
            if (k == 0) begin
                c_num = i_num;
                c_rem = '0;
                c_den = i_den;
            end else begin
                c_num = r_num[k-1];
                c_rem = r_rem[k-1];
                c_den = r_den[k-1];
            end
            c_cur = {c_rem, c_num[NW-1]};
            c_ge  = c_cur >= {1'b0, c_den};
            if (c_ge) begin
                n_rem[k] = DW'(c_cur - {1'b0, c_den});
            end else begin
                n_rem[k] = c_cur[DW-1:0];
            end
            n_num[k] = {c_num[NW-2:0], c_ge};
            n_den[k] = c_den;
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NW-2:0], i_valid};
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int k = 0; k < NW; k++) begin
                r_num[k] <= n_num[k];
                r_rem[k] <= n_rem[k];
                r_den[k] <= n_den[k];
            end
            for (int k = 1; k < NW; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid = r_v[NW-1];
    assign o_quot  = r_num[NW-1];
    assign o_side  = r_side[NW-1];

endmodule

// ----- hw/rtl/affine2x2_decompose_top.sv -----
`timescale 1ns / 1ps
// 2x2 matrix decomposition into rotation angle, scales and shears.
// input stream: one beat per matrix, s_axis_tdata holds the four Q3.12 entries
//   column 0 row 0, column 0 row 1, column 1 row 0, column 1 row 1 (lowest first).
// output stream: one beat per matrix, m_axis_tdata holds angle (binary angle),
//   scale_x, scale_y (Q5.12) and shear_x, shear_y (Q11.12, saturating);
//   m_axis_tuser carries the status code (ok, zero norm, shear saturated).
// throughput: one matrix per cycle while the output is not back-pressured.
// pipeline: a cordic (a fold register and CORDIC_STAGES rotation stages), the
//   root (17 digit stages plus a rounding register), the 34-stage scale divider,
//   the (18 + FRAC_BITS)-stage shear divider and seven single-register stages.
// stall: the whole pipeline advances together; while an output beat waits,
//   s_axis_tready is low until that beat is taken, and no beat is lost or
//   repeated.
// reset: synchronous active-low i_rst_n clears all valid bits; the block is
//   ready for input on the first cycle after reset.
module affine2x2_decompose_top import a2d_pkg::*; #(
    parameter int FRAC_BITS     = 12,
    parameter int CORDIC_STAGES = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // col0_row0, col0_row1, col1_row0, col1_row1
    input  logic [63:0]   s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // rotation_angle, scale_x, scale_y, shear_x, shear_y, zero pad
    output logic [103:0]  m_axis_tdata,
    // status
    output logic [1:0]    m_axis_tuser
);

`include "affine2x2_decompose_top_assert.svh"

    localparam int P_W         = IN_W + 1;
    localparam int PROD_W      = IN_W + P_W;
    localparam int NUM_W       = PROD_W + 1;
    localparam int SQ_W        = 2 * P_W;
    localparam int ROOT_W      = P_W;
    localparam int SHD_NW      = SCALE_W + FRAC_BITS;
    localparam int CORD_SIDE_W = SQ_W + 4 * NUM_W + 1;
    localparam int SQ_SIDE_W   = TURN_W + 4 * NUM_W + 1;
    localparam int SD0_SIDE_W  = TURN_W + 2;
    localparam int SH0_SIDE_W  = 4 + TURN_W + 1 + 2 * SCALE_W;

    localparam logic [NUM_W-1:0]  SC_POS_LIM = NUM_W'((2**(SCALE_W-1)) - 1);
    localparam logic [NUM_W-1:0]  SC_NEG_LIM = NUM_W'(2**(SCALE_W-1));
    localparam logic [SHD_NW-1:0] SH_POS_LIM = SHD_NW'((2**(SHEAR_W-1)) - 1);
    localparam logic [SHD_NW-1:0] SH_NEG_LIM = SHD_NW'(2**(SHEAR_W-1));

    logic en;
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // ---------------- stage 1: sums ----------------
    logic signed [IN_W-1:0] in_a, in_b, in_c, in_d;
    assign in_a = $signed(s_axis_tdata[15:0]);
    assign in_b = $signed(s_axis_tdata[31:16]);
    assign in_c = $signed(s_axis_tdata[47:32]);
    assign in_d = $signed(s_axis_tdata[63:48]);

    logic                   r1_v;
    logic signed [IN_W-1:0] r1_a, r1_b, r1_c, r1_d;
    logic signed [P_W-1:0]  r1_p, r1_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_a <= in_a;
            r1_b <= in_b;
            r1_c <= in_c;
            r1_d <= in_d;
            r1_p <= P_W'(in_a) + P_W'(in_d);
            r1_q <= P_W'(in_c) - P_W'(in_b);
        end
    end

    // ---------------- stage 2: products ----------------
    logic                     r2_v, r2_zn;
    logic signed [SQ_W-1:0]   r2_pp, r2_qq;
    logic signed [PROD_W-1:0] r2_prod [0:7];
    logic signed [P_W-1:0]    r2_p, r2_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_pp      <= SQ_W'(r1_p) * SQ_W'(r1_p);
            r2_qq      <= SQ_W'(r1_q) * SQ_W'(r1_q);
            r2_prod[0] <= PROD_W'(r1_p) * PROD_W'(r1_a);
            r2_prod[1] <= PROD_W'(r1_q) * PROD_W'(r1_b);
            r2_prod[2] <= PROD_W'(r1_q) * PROD_W'(r1_c);
            r2_prod[3] <= PROD_W'(r1_p) * PROD_W'(r1_d);
            r2_prod[4] <= PROD_W'(r1_q) * PROD_W'(r1_a);
            r2_prod[5] <= PROD_W'(r1_p) * PROD_W'(r1_b);
            r2_prod[6] <= PROD_W'(r1_p) * PROD_W'(r1_c);
            r2_prod[7] <= PROD_W'(r1_q) * PROD_W'(r1_d);
            r2_p       <= r1_p;
            r2_q       <= r1_q;
            r2_zn      <= (r1_p == '0) && (r1_q == '0);
        end
    end

    // ---------------- stage 3: norm square and S numerators ----------------
    logic                    r3_v, r3_zn;
    logic [SQ_W-1:0]         r3_rad;
    logic signed [NUM_W-1:0] r3_num [0:3];
    logic signed [P_W-1:0]   r3_p, r3_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_rad    <= $unsigned(r2_pp) + $unsigned(r2_qq);
            r3_num[0] <= NUM_W'(r2_prod[0]) - NUM_W'(r2_prod[1]);
            r3_num[1] <= NUM_W'(r2_prod[2]) + NUM_W'(r2_prod[3]);
            r3_num[2] <= NUM_W'(r2_prod[4]) + NUM_W'(r2_prod[5]);
            r3_num[3] <= NUM_W'(r2_prod[6]) - NUM_W'(r2_prod[7]);
            r3_p      <= r2_p;
            r3_q      <= r2_q;
            r3_zn     <= r2_zn;
        end
    end

    // ---------------- angle ----------------
    logic                    cord_v, cs_zn;
    logic [TURN_W-1:0]       cord_z;
    logic [CORD_SIDE_W-1:0]  cord_side;
    logic [SQ_W-1:0]         cs_rad;
    logic signed [NUM_W-1:0] cs_num [0:3];

    a2d_cordic #(
        .STAGES (CORDIC_STAGES),
        .DIN_W  (P_W),
        .SIDE_W (CORD_SIDE_W)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r3_v),
        .i_x     (r3_p),
        .i_y     (r3_q),
        .i_side  ({r3_rad, r3_num[3], r3_num[2], r3_num[1], r3_num[0], r3_zn}),
        .o_valid (cord_v),
        .o_z     (cord_z),
        .o_side  (cord_side)
    );

    assign {cs_rad, cs_num[3], cs_num[2], cs_num[1], cs_num[0], cs_zn} = cord_side;

    // ---------------- norm ----------------
    logic                    sq_v, sq_zn;
    logic [ROOT_W-1:0]       sq_n;
    logic [SQ_SIDE_W-1:0]    sq_side;
    logic [TURN_W-1:0]       sq_z;
    logic signed [NUM_W-1:0] sq_num [0:3];

    a2d_sqrt #(
        .RW     (ROOT_W),
        .SIDE_W (SQ_SIDE_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (cord_v),
        .i_rad   (cs_rad),
        .i_side  ({cord_z, cs_num[3], cs_num[2], cs_num[1], cs_num[0], cs_zn}),
        .o_valid (sq_v),
        .o_root  (sq_n),
        .o_side  (sq_side)
    );

    assign {sq_z, sq_num[3], sq_num[2], sq_num[1], sq_num[0], sq_zn} = sq_side;

    // ---------------- stage 4: magnitudes plus half divisor ----------------
    logic              r4_v, r4_zn;
    logic [NUM_W-1:0]  r4_dvd [0:3];
    logic              r4_sign [0:3];
    logic [ROOT_W-1:0] r4_den;
    logic [TURN_W-1:0] r4_z;
    logic [NUM_W-1:0]  n4_dvd [0:3];

    always_comb begin
        logic [NUM_W-1:0] mag;
        for (int i = 0; i < 4; i++) begin
            mag       = sq_num[i][NUM_W-1] ? NUM_W'(-sq_num[i]) : NUM_W'(sq_num[i]);
            n4_dvd[i] = mag + NUM_W'(sq_n >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en) begin
            r4_v <= sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                r4_dvd[i]  <= n4_dvd[i];
                r4_sign[i] <= sq_num[i][NUM_W-1];
            end
            r4_den <= sq_n;
            r4_z   <= sq_z;
            r4_zn  <= sq_zn;
        end
    end

    // ---------------- S entries ----------------
    logic                  sd_v, sd_zn;
    logic [NUM_W-1:0]      sd_q [0:3];
    logic                  sd_sign [0:3];
    logic [TURN_W-1:0]     sd_z;
    logic [SD0_SIDE_W-1:0] sd0_side;

    a2d_div #(
        .NW     (NUM_W),
        .DW     (ROOT_W),
        .SIDE_W (SD0_SIDE_W)
    ) u_div_s0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r4_v),
        .i_num   (r4_dvd[0]),
        .i_den   (r4_den),
        .i_side  ({r4_sign[0], r4_z, r4_zn}),
        .o_valid (sd_v),
        .o_quot  (sd_q[0]),
        .o_side  (sd0_side)
    );

    assign {sd_sign[0], sd_z, sd_zn} = sd0_side;

    for (genvar gi = 1; gi < 4; gi++) begin : g_div_s
        a2d_div #(
            .NW     (NUM_W),
            .DW     (ROOT_W),
            .SIDE_W (1)
        ) u_div_s (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (r4_v),
            .i_num   (r4_dvd[gi]),
            .i_den   (r4_den),
            .i_side  (r4_sign[gi]),
            .o_valid (),
            .o_quot  (sd_q[gi]),
            .o_side  (sd_sign[gi])
        );
    end

    // ---------------- stage 5: signed, saturated S entries ----------------
    logic                      r5_v, r5_zn;
    logic signed [SCALE_W-1:0] r5_s [0:3];
    logic [TURN_W-1:0]         r5_z;
    logic signed [SCALE_W-1:0] n5_s [0:3];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (!sd_sign[i]) begin
                n5_s[i] = (sd_q[i] > SC_POS_LIM) ? SCALE_MAX : $signed(sd_q[i][SCALE_W-1:0]);
            end else begin
                n5_s[i] = (sd_q[i] > SC_NEG_LIM) ? SCALE_MIN : -$signed(sd_q[i][SCALE_W-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (en) begin
            r5_v <= sd_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                r5_s[i] <= n5_s[i];
            end
            r5_z  <= sd_z;
            r5_zn <= sd_zn;
        end
    end

    // ---------------- stage 6: shear operands ----------------
    // shear_x is S10 over S00, shear_y is S01 over S11
    logic                      r6_v, r6_zn;
    logic [SHD_NW-1:0]         r6_dvd [0:1];
    logic [SCALE_W-1:0]        r6_den [0:1];
    logic                      r6_sign [0:1];
    logic                      r6_dz [0:1];
    logic                      r6_npos [0:1];
    logic                      r6_nneg [0:1];
    logic [TURN_W-1:0]         r6_z;
    logic signed [SCALE_W-1:0] r6_sx, r6_sy;
    logic [SHD_NW-1:0]         n6_dvd [0:1];
    logic [SCALE_W-1:0]        n6_den [0:1];

    always_comb begin
        logic [SCALE_W-1:0] mag_n;
        for (int j = 0; j < 2; j++) begin
            mag_n     = r5_s[2+j][SCALE_W-1] ? SCALE_W'(-r5_s[2+j]) : SCALE_W'(r5_s[2+j]);
            n6_den[j] = r5_s[j][SCALE_W-1] ? SCALE_W'(-r5_s[j]) : SCALE_W'(r5_s[j]);
            n6_dvd[j] = (SHD_NW'(mag_n) << FRAC_BITS) + SHD_NW'(n6_den[j] >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (en) begin
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 2; j++) begin
                r6_dvd[j]  <= n6_dvd[j];
                r6_den[j]  <= n6_den[j];
                r6_sign[j] <= r5_s[2+j][SCALE_W-1] ^ r5_s[j][SCALE_W-1];
                r6_dz[j]   <= (r5_s[j] == '0);
                r6_npos[j] <= !r5_s[2+j][SCALE_W-1] && (r5_s[2+j] != '0);
                r6_nneg[j] <= r5_s[2+j][SCALE_W-1];
            end
            r6_z  <= r5_z;
            r6_zn <= r5_zn;
            r6_sx <= r5_s[0];
            r6_sy <= r5_s[1];
        end
    end

    // ---------------- shears ----------------
    logic                      h_v, h_zn;
    logic [SHD_NW-1:0]         h_q [0:1];
    logic                      h_sign [0:1];
    logic                      h_dz [0:1];
    logic                      h_npos [0:1];
    logic                      h_nneg [0:1];
    logic [TURN_W-1:0]         h_z;
    logic signed [SCALE_W-1:0] h_sx, h_sy;
    logic [SH0_SIDE_W-1:0]     sh0_side;
    logic [3:0]                sh1_side;

    a2d_div #(
        .NW     (SHD_NW),
        .DW     (SCALE_W),
        .SIDE_W (SH0_SIDE_W)
    ) u_div_h0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r6_v),
        .i_num   (r6_dvd[0]),
        .i_den   (r6_den[0]),
        .i_side  ({r6_sign[0], r6_dz[0], r6_npos[0], r6_nneg[0],
                   r6_z, r6_zn, r6_sx, r6_sy}),
        .o_valid (h_v),
        .o_quot  (h_q[0]),
        .o_side  (sh0_side)
    );

    a2d_div #(
        .NW     (SHD_NW),
        .DW     (SCALE_W),
        .SIDE_W (4)
    ) u_div_h1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r6_v),
        .i_num   (r6_dvd[1]),
        .i_den   (r6_den[1]),
        .i_side  ({r6_sign[1], r6_dz[1], r6_npos[1], r6_nneg[1]}),
        .o_valid (),
        .o_quot  (h_q[1]),
        .o_side  (sh1_side)
    );

    assign {h_sign[0], h_dz[0], h_npos[0], h_nneg[0], h_z, h_zn, h_sx, h_sy} = sh0_side;
    assign {h_sign[1], h_dz[1], h_npos[1], h_nneg[1]} = sh1_side;

    // ---------------- stage 7: output register ----------------
    logic                      r7_v;
    logic [ANG_W-1:0]          r7_ang;
    logic signed [SCALE_W-1:0] r7_sx, r7_sy;
    logic signed [SHEAR_W-1:0] r7_hx, r7_hy;
    t_status                   r7_st;

    logic signed [SHEAR_W-1:0] n7_h [0:1];
    logic                      n7_hit;
    logic [TURN_W-1:0]         n7_zr;

    // shear clamp and zero-divisor handling
    always_comb begin
        n7_hit = 1'b0;
        for (int j = 0; j < 2; j++) begin
            if (h_dz[j]) begin
                n7_hit  = 1'b1;
                n7_h[j] = h_npos[j] ? SHEAR_MAX : (h_nneg[j] ? SHEAR_MIN : '0);
            end else if (!h_sign[j]) begin
                if (h_q[j] > SH_POS_LIM) begin
                    n7_hit  = 1'b1;
                    n7_h[j] = SHEAR_MAX;
                end else begin
                    n7_h[j] = $signed(h_q[j][SHEAR_W-1:0]);
                end
            end else begin
                if (h_q[j] > SH_NEG_LIM) begin
                    n7_hit  = 1'b1;
                    n7_h[j] = SHEAR_MIN;
                end else begin
                    n7_h[j] = -$signed(h_q[j][SHEAR_W-1:0]);
                end
            end
        end
        n7_zr = h_z + TURN_ROUND;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (en) begin
            r7_v <= h_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (h_zn) begin
                r7_ang <= '0;
                r7_sx  <= '0;
                r7_sy  <= '0;
                r7_hx  <= '0;
                r7_hy  <= '0;
                r7_st  <= ST_ZERO_NORM;
            end else begin
                r7_ang <= n7_zr[TURN_W-1 -: ANG_W];
                r7_sx  <= h_sx;
                r7_sy  <= h_sy;
                r7_hx  <= n7_h[0];
                r7_hy  <= n7_h[1];
                r7_st  <= n7_hit ? ST_SHEAR_SAT : ST_OK;
            end
        end
    end

    assign m_axis_tvalid = r7_v;
    assign m_axis_tdata  = {4'b0000, r7_hy, r7_hx, r7_sy, r7_sx, r7_ang};
    assign m_axis_tuser  = r7_st;

    // ---------------- checks ----------------
    logic r7_all_zero;
    assign r7_all_zero = (r7_ang == '0) && (r7_sx == '0) && (r7_sy == '0)
                         && (r7_hx == '0) && (r7_hy == '0);

    `A2D_ASSERT(a_zero_norm_clears, r7_v && (r7_st == ST_ZERO_NORM), r7_all_zero)
    `A2D_ASSERT(a_ok_has_scales, r7_v && (r7_st == ST_OK), (r7_sx != '0) && (r7_sy != '0))
    `A2D_ASSERT(a_norm_nonzero, r4_v && !r4_zn, r4_den != '0)
    `A2D_ASSERT_NEXT(a_zn_radicand, en && r2_v && r2_zn, r3_v && (r3_rad == '0))

endmodule
